// ===== src/cwg_pkg.sv =====
`default_nettype none

package cwg_pkg;

  localparam int unsigned MaxLengthDef    = 32768;
  localparam int unsigned PhaseBitsDef    = 24;
  localparam int unsigned CoefFracBitsDef = 16;

  localparam int unsigned IdxW     = 15;
  localparam int unsigned LenW     = 16;
  localparam int unsigned TypeW    = 2;
  localparam int unsigned CfgAddrW = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [LenW-1:0]  LenRst  = 16'd1024;
  localparam logic [TypeW-1:0] TypeRst = 2'd0;

  typedef enum logic [CfgAddrW-1:0] {
    CfgWinType = 1'b0,
    CfgWinLen  = 1'b1
  } cfg_reg_e;

  // fold, square, five Horner steps, final step
  localparam int unsigned CosLat = 8;

  typedef logic [30:0] q30_t;
  typedef logic [29:0] wgt_t;

  // (pi/2)^(2k)/(2k)! in Q30
  localparam q30_t CosD [7] = '{
    31'd1073741824, 31'd1324675879, 31'd272375561, 31'd22401992,
    31'd987048, 31'd27060, 31'd506
  };

  // a0..a3 in Q30: Hann, Hamming, exact Blackman, Blackman-Harris
  localparam wgt_t WinW [4][4] = '{
    '{30'd536870912, 30'd536870912, 30'd0,         30'd0},
    '{30'd579820585, 30'd493921239, 30'd0,         30'd0},
    '{30'd458048291, 30'd533177905, 30'd82515628,  30'd0},
    '{30'd385204879, 30'd524297395, 30'd151698245, 30'd12541305}
  };

endpackage

`default_nettype wire

// ===== src/cwg_div.sv =====
`default_nettype none

module cwg_div #(
  parameter int unsigned PhaseBits = cwg_pkg::PhaseBitsDef,
  parameter int unsigned DivW      = 15
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  logic [cwg_pkg::IdxW-1:0]   idx_i,
  input  logic [DivW-1:0]            div_i,
  input  logic [cwg_pkg::TypeW-1:0]  type_i,
  output logic                       vld_o,
  output logic [PhaseBits-1:0]       phase_o,
  output logic [cwg_pkg::TypeW-1:0]  type_o
);
  import cwg_pkg::*;

  localparam int unsigned NumW = IdxW + 1 + PhaseBits;

  logic [DivW-1:0]      rem_q [NumW];
  logic [DivW-1:0]      div_q [NumW];
  logic [NumW-1:0]      num_q [NumW];
  logic [PhaseBits-1:0] quo_q [NumW];
  logic [TypeW-1:0]     typ_q [NumW];
  logic [NumW-1:0]      vld_q;
  logic [NumW-1:0]      num0;

  assign num0 = (NumW'(idx_i) << PhaseBits) + NumW'(div_i >> 1);

  for (genvar s = 0; s < NumW; s++) begin : g_step
    localparam int unsigned Bit = NumW - 1 - s;
    logic [DivW-1:0]      rem_in, div_in, rem_nx;
    logic [NumW-1:0]      num_in;
    logic [PhaseBits-1:0] quo_in, quo_nx;
    logic [TypeW-1:0]     typ_in;
    logic                 vld_in, ge;
    logic [DivW:0]        rem_sh, diff;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign div_in = div_i;
      assign num_in = num0;
      assign quo_in = '0;
      assign typ_in = type_i;
      assign vld_in = vld_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign div_in = div_q[s-1];
      assign num_in = num_q[s-1];
      assign quo_in = quo_q[s-1];
      assign typ_in = typ_q[s-1];
      assign vld_in = vld_q[s-1];
    end

    assign rem_sh = {rem_in, num_in[Bit]};
    assign ge     = rem_sh >= {1'b0, div_in};
    assign diff   = rem_sh - {1'b0, div_in};
    assign rem_nx = ge ? diff[DivW-1:0] : rem_sh[DivW-1:0];

    if (Bit < PhaseBits) begin : g_quo
      always_comb begin
        quo_nx      = quo_in;
        quo_nx[Bit] = ge;
      end
    end else begin : g_skip
      assign quo_nx = quo_in;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_nx;
        div_q[s] <= div_in;
        num_q[s] <= num_in;
        quo_q[s] <= quo_nx;
        typ_q[s] <= typ_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end
  end

  assign vld_o   = vld_q[NumW-1];
  assign phase_o = quo_q[NumW-1];
  assign type_o  = typ_q[NumW-1];

endmodule

`default_nettype wire

// ===== src/cwg_cos.sv =====
`default_nettype none

module cwg_cos #(
  parameter int unsigned PhaseBits = cwg_pkg::PhaseBitsDef
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [PhaseBits-1:0] phase_i,
  output logic signed [31:0]   cos_o
);
  import cwg_pkg::*;

  localparam logic [PhaseBits:0] Full    = (PhaseBits+1)'(1) << PhaseBits;
  localparam logic [PhaseBits:0] Half    = Full >> 1;
  localparam logic [PhaseBits:0] Quarter = Full >> 2;
  localparam logic [63:0]        RndQ30  = 64'd1 << 29;
  localparam logic signed [33:0] OneQ30  = 34'sd1 <<< 30;

  logic [PhaseBits:0] p_f;
  logic               neg_d;
  logic [63:0]        u_wide;
  q30_t               u_q, y_q;
  logic               nf_q, ny_q;
  logic [63:0]        sq;

  always_comb begin
    p_f   = {1'b0, phase_i};
    neg_d = 1'b0;
    if (p_f > Half) begin
      p_f = Full - p_f;
    end
    if (p_f > Quarter) begin
      p_f   = Half - p_f;
      neg_d = 1'b1;
    end
    u_wide = 64'(p_f) << (32 - PhaseBits);
  end

  assign sq = 64'(u_q) * 64'(u_q) + RndQ30;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q  <= u_wide[30:0];
      nf_q <= neg_d;
      y_q  <= sq[60:30];
      ny_q <= nf_q;
    end
  end

  q30_t acc_q [5];
  q30_t yh_q  [5];
  logic nh_q  [5];

  for (genvar j = 0; j < 5; j++) begin : g_horner
    q30_t        acc_in, y_in;
    logic        neg_in;
    logic [63:0] prod;

    if (j == 0) begin : g_first
      assign acc_in = CosD[6];
      assign y_in   = y_q;
      assign neg_in = ny_q;
    end else begin : g_next
      assign acc_in = acc_q[j-1];
      assign y_in   = yh_q[j-1];
      assign neg_in = nh_q[j-1];
    end

    assign prod = 64'(acc_in) * 64'(y_in) + RndQ30;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[j] <= CosD[5-j] - prod[60:30];
        yh_q[j]  <= y_in;
        nh_q[j]  <= neg_in;
      end
    end
  end

  logic [63:0]        prod_f;
  logic signed [33:0] cd, cm;
  logic signed [31:0] cos_d, cos_q;

  assign prod_f = 64'(acc_q[4]) * 64'(yh_q[4]) + RndQ30;

  always_comb begin
    cd = $signed(34'(CosD[0])) - $signed(prod_f[63:30]);
    cm = cd;
    if (cd < 34'sd0) begin
      cm = 34'sd0;
    end
    if (cd > OneQ30) begin
      cm = OneQ30;
    end
    cos_d = nh_q[4] ? -32'(cm) : 32'(cm);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= cos_d;
    end
  end

  assign cos_o = cos_q;

endmodule

`default_nettype wire

// ===== src/cosine_window_coefficient_generator.sv =====
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// The phase divider is PHASE_BITS + 16 stages of one restoring step each, followed
// by harmonic, eight cosine, weight, sum and output stages.
// Reset clears all valid bits and loads Hann with a length of 1024.
`default_nettype none

module cosine_window_coefficient_generator #(
  parameter int unsigned MaxLength    = cwg_pkg::MaxLengthDef,
  parameter int unsigned PhaseBits    = cwg_pkg::PhaseBitsDef,
  parameter int unsigned CoefFracBits = cwg_pkg::CoefFracBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cwg_pkg::CfgAddrW-1:0]   cfg_idx_i,
  input  logic [cwg_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [cwg_pkg::IdxW-1:0]       sample_index_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [CoefFracBits+1:0] coefficient_o
);
  import cwg_pkg::*;

  localparam int unsigned DivW = $clog2(MaxLength);
  localparam int unsigned OutW = CoefFracBits + 2;
  localparam int unsigned Sh   = 60 - CoefFracBits;
  localparam logic signed [63:0] OneS = 64'sd1 <<< CoefFracBits;
  localparam logic signed [63:0] RndS = 64'sd1 <<< (Sh - 1);

  logic [TypeW-1:0] type_q;
  logic [LenW-1:0]  len_q;
  logic             en;
  logic             out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q <= TypeRst;
      len_q  <= LenRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgWinType: type_q <= cfg_wdata_i[TypeW-1:0];
        CfgWinLen:  len_q  <= cfg_wdata_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  logic [LenW:0]   len_c;
  logic [LenW:0]   len_m1;
  logic [DivW-1:0] div_c;

  always_comb begin
    len_c = {1'b0, len_q};
    if (len_c < (LenW+1)'(2)) begin
      len_c = (LenW+1)'(2);
    end
    if (len_c > (LenW+1)'(MaxLength)) begin
      len_c = (LenW+1)'(MaxLength);
    end
    len_m1 = len_c - (LenW+1)'(1);
    div_c  = len_m1[DivW-1:0];
  end

  logic                 div_vld;
  logic [PhaseBits-1:0] phase;
  logic [TypeW-1:0]     div_type;

  cwg_div #(
    .PhaseBits(PhaseBits),
    .DivW     (DivW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_valid_i),
    .idx_i  (sample_index_i),
    .div_i  (div_c),
    .type_i (type_q),
    .vld_o  (div_vld),
    .phase_o(phase),
    .type_o (div_type)
  );

  logic [PhaseBits-1:0] ph1_q, ph2_q, ph3_q;
  logic [TypeW-1:0]     typh_q;
  logic                 vldh_q;
  logic [PhaseBits-1:0] ph2_d;

  assign ph2_d = {phase[PhaseBits-2:0], 1'b0};

  always_ff @(posedge clk_i) begin
    if (en) begin
      ph1_q  <= phase;
      ph2_q  <= ph2_d;
      ph3_q  <= ph2_d + phase;
      typh_q <= div_type;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vldh_q <= 1'b0;
    end else if (en) begin
      vldh_q <= div_vld;
    end
  end

  logic signed [31:0] c1, c2, c3;

  cwg_cos #(.PhaseBits(PhaseBits)) u_cos1 (
    .clk_i(clk_i), .en_i(en), .phase_i(ph1_q), .cos_o(c1)
  );
  cwg_cos #(.PhaseBits(PhaseBits)) u_cos2 (
    .clk_i(clk_i), .en_i(en), .phase_i(ph2_q), .cos_o(c2)
  );
  cwg_cos #(.PhaseBits(PhaseBits)) u_cos3 (
    .clk_i(clk_i), .en_i(en), .phase_i(ph3_q), .cos_o(c3)
  );

  logic [CosLat-1:0] vldc_q;
  logic [TypeW-1:0]  typc_q [CosLat];

  always_ff @(posedge clk_i) begin
    if (en) begin
      typc_q[0] <= typh_q;
      for (int i = 1; i < CosLat; i++) begin
        typc_q[i] <= typc_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vldc_q <= '0;
    end else if (en) begin
      vldc_q <= {vldc_q[CosLat-2:0], vldh_q};
    end
  end

  logic signed [31:0] w1s, w2s, w3s;
  logic signed [63:0] m0_q, m1_q, m2_q, m3_q;
  logic               vldm_q;
  wgt_t               w0;

  always_comb begin
    w0  = WinW[typc_q[CosLat-1]][0];
    w1s = $signed({2'b00, WinW[typc_q[CosLat-1]][1]});
    w2s = $signed({2'b00, WinW[typc_q[CosLat-1]][2]});
    w3s = $signed({2'b00, WinW[typc_q[CosLat-1]][3]});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m0_q <= $signed({4'b0000, w0, 30'd0});
      m1_q <= 64'(w1s) * 64'(c1);
      m2_q <= 64'(w2s) * 64'(c2);
      m3_q <= 64'(w3s) * 64'(c3);
    end
  end

  logic signed [63:0] s_q;
  logic               vlds_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q <= m0_q - m1_q + m2_q - m3_q + RndS;
    end
  end

  logic signed [63:0]     v;
  logic signed [OutW-1:0] coef_d, coef_q;

  always_comb begin
    v = s_q >>> Sh;
    if (v > OneS) begin
      v = OneS;
    end
    if (v < -OneS) begin
      v = -OneS;
    end
    coef_d = OutW'(v);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      coef_q <= coef_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vldm_q    <= 1'b0;
      vlds_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vldm_q    <= vldc_q[CosLat-1];
      vlds_q    <= vldm_q;
      out_vld_q <= vlds_q;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign coefficient_o = coef_q;

`ifndef SYNTHESIS
  a_coef_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (64'(coefficient_o) <= OneS && 64'(coefficient_o) >= -OneS))
    else $error("coefficient out of range");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(vldc_q) && $stable(vldm_q) && $stable(vlds_q)))
    else $error("pipeline moved during stall");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vlds_q) |=> out_vld_q)
    else $error("result lost at output stage");
`endif

endmodule

`default_nettype wire
